// File: src/sacl_pkg.sv
// Package for the set-associative LRU cache tag store.
// Holds the operation codes, register indexes, reset values and the lookup result type.
// Depends on nothing; sacl_lookup and the top level import it.
package sacl_pkg;

    // Width of the running hit, miss and eviction totals.
    localparam int TOTAL_W = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Configuration reset values.
    localparam logic [2:0] SET_BITS_RST    = 3'd4;
    localparam logic [5:0] BLOCK_BITS_RST  = 6'd4;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

    // Access operations carried by a request.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_FETCH  = 2'd3
    } t_op;

    // Outcome of one lookup, passed from the lookup engine to the top level.
    typedef struct packed {
        logic hit;
        logic evict;
    } t_look_res;

endpackage

// File: src/sacl_addr_split.sv
// Address splitter: derives the set index and the tag from a byte address.
// Uses the configured set and block bit counts; no package content is needed.
module sacl_addr_split #(
    parameter int MAX_SET_BITS  = 6,
    parameter int ADDRESS_WIDTH = 64,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic [63:0]              i_address,
    input  logic [2:0]               i_set_bits,
    input  logic [5:0]               i_block_bits,
    output logic [SET_W-1:0]         o_set,
    output logic [ADDRESS_WIDTH-1:0] o_tag
);

    logic [ADDRESS_WIDTH-1:0] addr_m;
    logic [ADDRESS_WIDTH-1:0] idx_full;
    logic [2:0]               eff_s;
    logic [6:0]               tag_shift;

    // Set bits above the supported maximum act as the maximum.
    assign eff_s = (int'(i_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : i_set_bits;

    // Bits above the address width are ignored; a shift past the width yields zero.
    assign addr_m    = i_address[ADDRESS_WIDTH-1:0];
    assign tag_shift = {4'b0000, eff_s} + {1'b0, i_block_bits};
    assign idx_full  = addr_m >> i_block_bits;
    assign o_tag     = addr_m >> tag_shift;

    // Keep only the configured number of index bits.
    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            o_set[i] = idx_full[i] & (i < int'(eff_s));
        end
    end

endmodule

// File: src/sacl_lookup.sv
// Lookup engine: per-set valid and age memory, tag memory and a single tag and age
// comparator that walks the ways of a set one per cycle. Depends on sacl_pkg.
module sacl_lookup #(
    parameter int MAX_SET_BITS  = 6,
    parameter int MAX_WAYS      = 8,
    parameter int ADDRESS_WIDTH = 64,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int CNT_W = $clog2(MAX_WAYS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [SET_W-1:0]         i_set,
    input  logic [ADDRESS_WIDTH-1:0] i_tag,
    input  logic [CNT_W-1:0]         i_ways,
    input  logic                     i_commit,
    output logic                     o_done,
    output sacl_pkg::t_look_res      o_res
);

    import sacl_pkg::*;

    localparam int SET_COUNT = 1 << SET_W;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W     = WAY_W;
    localparam int TAG_DEPTH = 1 << (SET_W + WAY_W);

    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    } t_row;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SCAN,
        E_DONE
    } t_state;

    t_state                   r_state;
    t_row                     meta_mem [SET_COUNT];
    logic [ADDRESS_WIDTH-1:0] tag_mem  [TAG_DEPTH];
    t_row                     r_meta_q;
    logic [ADDRESS_WIDTH-1:0] r_tag_q;
    logic                     r_seen_q;
    logic [SET_COUNT-1:0]     r_row_seen;
    logic [WAY_W-1:0]         r_way;
    logic [WAY_W-1:0]         r_sel;
    logic [WAY_W-1:0]         r_inv_sel;
    logic [WAY_W-1:0]         r_max_sel;
    logic [AGE_W-1:0]         r_inv_age;
    logic [AGE_W-1:0]         r_max_age;
    logic                     r_hit;
    logic                     r_found;

    t_row             reset_row;
    t_row             row;
    t_row             new_row;
    logic             cur_valid;
    logic [AGE_W-1:0] cur_age;
    logic             cur_hit;
    logic             cur_last;
    logic [WAY_W-1:0] rd_way;
    logic             tag_rd_en;
    logic             wr_en;
    logic             start_en;
    logic [WAY_W-1:0] sel;
    logic [AGE_W-1:0] sel_age;

    // A set never written since reset reads as invalid lines with ages equal to the way index.
    always_comb begin
        reset_row.valid = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            reset_row.age[w] = AGE_W'(w);
        end
    end

    assign row = r_seen_q ? r_meta_q : reset_row;

    // Shared comparator inputs for the way under inspection.
    assign cur_valid = row.valid[r_way];
    assign cur_age   = row.age[r_way];
    assign cur_hit   = cur_valid && (r_tag_q == i_tag);
    assign cur_last  = (CNT_W'(r_way) == (i_ways - CNT_W'(1)));

    assign start_en  = (r_state == E_IDLE) && i_start;
    assign tag_rd_en = start_en || (r_state == E_SCAN);
    assign rd_way    = (r_state == E_IDLE) ? '0 : r_way + WAY_W'(1);
    assign wr_en     = (r_state == E_DONE) && i_commit;

    // Pick the touched way: the hit, else the youngest free line, else the oldest line.
    assign sel     = r_hit ? r_sel : (r_found ? r_inv_sel : r_max_sel);
    assign sel_age = row.age[sel];

    // New ages: the touched way becomes the youngest, younger used ways age by one.
    always_comb begin
        new_row = row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (CNT_W'(w) < i_ways) begin
                if (WAY_W'(w) == sel) begin
                    new_row.valid[w] = 1'b1;
                    new_row.age[w]   = '0;
                end else if (row.age[w] < sel_age) begin
                    new_row.age[w] = row.age[w] + AGE_W'(1);
                end
            end
        end
    end

    assign o_done      = (r_state == E_DONE);
    assign o_res.hit   = r_hit;
    assign o_res.evict = !r_hit && !r_found;

    // Set metadata memory: one row read at the start of a lookup, written back on commit.
    always_ff @(posedge i_clk) begin
        if (start_en) begin
            r_meta_q <= meta_mem[i_set];
        end
        if (wr_en) begin
            meta_mem[i_set] <= new_row;
        end
    end

    // Tag memory: one way read per cycle during the scan, the victim written on a miss.
    always_ff @(posedge i_clk) begin
        if (tag_rd_en) begin
            r_tag_q <= tag_mem[{i_set, rd_way}];
        end
        if (wr_en && !r_hit) begin
            tag_mem[{i_set, sel}] <= i_tag;
        end
    end

    // Sequencer and scan trackers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= E_IDLE;
            r_row_seen <= '0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_state  <= E_SCAN;
                        r_way    <= '0;
                        r_hit    <= 1'b0;
                        r_found  <= 1'b0;
                        r_seen_q <= r_row_seen[i_set];
                    end
                end
                E_SCAN: begin
                    if (cur_hit) begin
                        r_hit <= 1'b1;
                        r_sel <= r_way;
                    end
                    if (!cur_valid && (!r_found || (cur_age < r_inv_age))) begin
                        r_found   <= 1'b1;
                        r_inv_sel <= r_way;
                        r_inv_age <= cur_age;
                    end
                    if ((r_way == '0) || (cur_age > r_max_age)) begin
                        r_max_sel <= r_way;
                        r_max_age <= cur_age;
                    end
                    if (cur_hit || cur_last) begin
                        r_state <= E_DONE;
                    end else begin
                        r_way <= r_way + WAY_W'(1);
                    end
                end
                E_DONE: begin
                    if (i_commit) begin
                        r_state           <= E_IDLE;
                        r_row_seen[i_set] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache tag store (hit and miss simulator).
// Depends on sacl_pkg, sacl_addr_split and sacl_lookup.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------------------
//  request  | i_in_valid / o_in_ready    | i_operation, i_address
//  result   | o_out_valid / i_out_ready  | o_hit, o_miss, o_eviction, o_last_of_item,
//           |                            | o_hit_total, o_miss_total, o_eviction_total
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A load or store gives one result after acceptance; a modify adds a second result for
// its write pass; a fetch is accepted but starts no lookup and gives no result.
// The scan is paced by the single tag comparator, which inspects one way per cycle and
// stops at the first hit. The block takes requests and register writes again once the
// last result is registered.
// After reset every set reads as empty through per-set flags, so no clearing pass is needed.
// A result waiting in the output register does not block the next request; only the
// write-back of the following result waits for the output register to drain.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS  = 6,
    parameter int MAX_WAYS      = 8,
    parameter int ADDRESS_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic [63:0]                         i_address,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic                                o_miss,
    output logic                                o_eviction,
    output logic                                o_last_of_item,
    output logic [sacl_pkg::TOTAL_W-1:0]        o_hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]        o_miss_total,
    output logic [sacl_pkg::TOTAL_W-1:0]        o_eviction_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import sacl_pkg::*;

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int CNT_W = $clog2(MAX_WAYS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_START,
        S_WAIT
    } t_state;

    t_state                   r_state;
    logic [2:0]               r_set_bits;
    logic [5:0]               r_block_bits;
    logic [3:0]               r_ways_in_use;
    logic [63:0]              r_addr;
    logic                     r_modify;
    logic                     r_second;
    logic [SET_W-1:0]         r_set;
    logic [ADDRESS_WIDTH-1:0] r_tag;
    logic                     r_out_valid;
    logic                     r_hit;
    logic                     r_miss;
    logic                     r_eviction;
    logic                     r_last;
    logic [TOTAL_W-1:0]       r_hit_total;
    logic [TOTAL_W-1:0]       r_miss_total;
    logic [TOTAL_W-1:0]       r_eviction_total;

    logic [TOTAL_W-1:0]       n_hit_total;
    logic [TOTAL_W-1:0]       n_miss_total;
    logic [TOTAL_W-1:0]       n_eviction_total;
    logic [SET_W-1:0]         split_set;
    logic [ADDRESS_WIDTH-1:0] split_tag;
    logic [CNT_W-1:0]         eff_ways;
    logic                     eng_done;
    t_look_res                eng_res;
    logic                     commit;
    logic                     in_accept;

    // Registers only change while no request is in flight.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;

    // Ways in use: zero acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (r_ways_in_use == '0) begin
            eff_ways = CNT_W'(1);
        end else if (int'(r_ways_in_use) > MAX_WAYS) begin
            eff_ways = CNT_W'(MAX_WAYS);
        end else begin
            eff_ways = CNT_W'(r_ways_in_use);
        end
    end

    sacl_addr_split #(
        .MAX_SET_BITS  (MAX_SET_BITS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_split (
        .i_address    (r_addr),
        .i_set_bits   (r_set_bits),
        .i_block_bits (r_block_bits),
        .o_set        (split_set),
        .o_tag        (split_tag)
    );

    sacl_lookup #(
        .MAX_SET_BITS  (MAX_SET_BITS),
        .MAX_WAYS      (MAX_WAYS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_START),
        .i_set    (r_set),
        .i_tag    (r_tag),
        .i_ways   (eff_ways),
        .i_commit (commit),
        .o_done   (eng_done),
        .o_res    (eng_res)
    );

    // A finished lookup is committed once the output register can take its result.
    assign commit = (r_state == S_WAIT) && eng_done && (!r_out_valid || i_out_ready);

    // Saturating totals after this lookup.
    always_comb begin
        n_hit_total      = r_hit_total;
        n_miss_total     = r_miss_total;
        n_eviction_total = r_eviction_total;
        if (commit) begin
            if (eng_res.hit) begin
                if (r_hit_total != '1) begin
                    n_hit_total = r_hit_total + TOTAL_W'(1);
                end
            end else begin
                if (r_miss_total != '1) begin
                    n_miss_total = r_miss_total + TOTAL_W'(1);
                end
                if (eng_res.evict && (r_eviction_total != '1)) begin
                    n_eviction_total = r_eviction_total + TOTAL_W'(1);
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= SET_BITS_RST;
            r_block_bits  <= BLOCK_BITS_RST;
            r_ways_in_use <= WAYS_IN_USE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[2:0];
                CFG_BLOCK_BITS:  r_block_bits  <= i_cfg_data[5:0];
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Request sequencer, totals and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_hit_total      <= '0;
            r_miss_total     <= '0;
            r_eviction_total <= '0;
        end else begin
            r_hit_total      <= n_hit_total;
            r_miss_total     <= n_miss_total;
            r_eviction_total <= n_eviction_total;

            if (commit) begin
                r_out_valid <= 1'b1;
                r_hit       <= eng_res.hit;
                r_miss      <= !eng_res.hit;
                r_eviction  <= eng_res.evict;
                r_last      <= !(r_modify && !r_second);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_operation != OP_FETCH)) begin
                        r_addr   <= i_address;
                        r_modify <= (i_operation == OP_MODIFY);
                        r_second <= 1'b0;
                        r_state  <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_set   <= split_set;
                    r_tag   <= split_tag;
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (commit) begin
                        if (r_modify && !r_second) begin
                            r_second <= 1'b1;
                            r_state  <= S_START;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_hit;
    assign o_miss           = r_miss;
    assign o_eviction       = r_eviction;
    assign o_last_of_item   = r_last;
    assign o_hit_total      = r_hit_total;
    assign o_miss_total     = r_miss_total;
    assign o_eviction_total = r_eviction_total;

    // The lookup engine only finishes while the sequencer is waiting for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (r_state == S_WAIT))
        else $error("lookup finished outside the wait state");

    // A new lookup is only started when the engine is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> !eng_done)
        else $error("lookup started while the engine was busy");

    // An eviction is always reported as a miss.
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eviction) |-> (r_miss && !r_hit))
        else $error("eviction reported without a miss");

    // Totals never decrease outside reset.
    a_totals_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_hit_total >= $past(r_hit_total))
                         && (r_miss_total >= $past(r_miss_total))
                         && (r_eviction_total >= $past(r_eviction_total))))
        else $error("running total decreased");

endmodule
